// ----- hw/rtl/lte_sss_pkg.sv -----
// Shared types, constants and helper functions of the SSS sequence generator.
package lte_sss_pkg;

	localparam int unsigned SEQ_LEN     = 31;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [4:0] TAPS_S = 5'h05;
	localparam logic [4:0] TAPS_C = 5'h09;
	localparam logic [4:0] TAPS_Z = 5'h17;

	localparam logic [4:0] LAST_N     = 5'd30;
	localparam logic [5:0] LAST_INDEX = 6'd61;

	// One decoded request, as handed from front to back
	typedef struct packed {
		logic [4:0] even_shift;
		logic [4:0] odd_shift;
		logic [2:0] z_shift;
		logic [1:0] sector;
	} job_t;

	// Build a length-31 m-sequence; a set bit stands for the value -1
	function automatic logic [30:0] mseq(input logic [4:0] taps);
		logic [30:0] seq;
		logic        v;
		seq    = '0;
		seq[4] = 1'b1;
		for (int i = 0; i < 26; i++) begin
			v = 1'b0;
			for (int k = 0; k < 5; k++) begin
				if (taps[k]) begin
					v = v ^ seq[i + k];
				end
			end
			seq[i + 5] = v;
		end
		return seq;
	endfunction

	localparam logic [30:0] S_SEQ = mseq(TAPS_S);
	localparam logic [30:0] C_SEQ = mseq(TAPS_C);
	localparam logic [30:0] Z_SEQ = mseq(TAPS_Z);

	// Quotient of a narrow value by a constant, by threshold counting
	function automatic logic [3:0] quot_small(input logic [7:0] v, input int unsigned d);
		logic [3:0] q;
		q = '0;
		for (int unsigned k = 1; k <= 8; k++) begin
			if (32'(v) >= k * d) begin
				q = q + 4'd1;
			end
		end
		return q;
	endfunction

	// Triangular number q*(q+1)/2 for a small q
	function automatic logic [6:0] tri_num(input logic [3:0] q);
		logic [7:0] p;
		p = {4'b0, q} * ({4'b0, q} + 8'd1);
		return p[7:1];
	endfunction

	// (a + b) mod 31 for operands below 31
	function automatic logic [4:0] add_mod31(input logic [4:0] a, input logic [4:0] b);
		logic [5:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 6'(SEQ_LEN)) begin
			s = s - 6'(SEQ_LEN);
		end
		return s[4:0];
	endfunction

endpackage

// ----- hw/rtl/lte_sss_sequence_generator_unit.sv -----
// Top level of the LTE secondary synchronisation sequence generator.
//
// Request channel: cell_id (0..503) and subframe_five are taken at a rising
// edge where start is high and busy is low. Each request yields 62 results,
// elements 0..61 in order, one per cycle: element_index, negative (1 = -1)
// and last on element 61, each valid for the single cycle strobe is high.
// The receiver cannot stall; every strobe cycle is a delivered result.
// The first element of a request reaches the ports through three decode
// stages, the queue, the back end's job register and the output register.
// The back end's element counter emits one element per cycle and takes the
// next request only after the last element of the one before; successive
// requests play out back to back. Up to QUEUE_DEPTH requests may
// be held between the request port and the back end; busy rises when all
// are in use and falls as the back end picks up the next one.
// Reset clears all pending requests and the element counter; no strobe is
// given until a new request arrives.
module lte_sss_sequence_generator_unit #(
	parameter int unsigned QUEUE_DEPTH = lte_sss_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [8:0] cell_id,
	input  logic       subframe_five,
	output logic       strobe,
	output logic [5:0] element_index,
	output logic       negative,
	output logic       last
);

	logic              push, pop, head_valid;
	lte_sss_pkg::job_t push_job, head_job;

	lte_sss_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cell_id      (cell_id),
		.subframe_five(subframe_five),
		.release_job  (pop),
		.push         (push),
		.push_job     (push_job)
	);

	lte_sss_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.head_valid(head_valid),
		.head_job  (head_job)
	);

	lte_sss_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (head_valid),
		.job          (head_job),
		.pop          (pop),
		.strobe       (strobe),
		.element_index(element_index),
		.negative     (negative),
		.last         (last)
	);

endmodule

// ----- hw/rtl/lte_sss_front.sv -----
// Front end: takes requests, splits the identity and works out the cyclic shifts.
module lte_sss_front #(
	parameter int unsigned DEPTH = lte_sss_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [8:0]          cell_id,
	input  logic                subframe_five,
	input  logic                release_job,
	output logic                push,
	output lte_sss_pkg::job_t   push_job
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] inflight_q;
	logic             accept;

	logic       valid_s1, valid_s2, valid_s3;
	logic [8:0] cell_id_s1;
	logic       sf5_s1, sf5_s2, sf5_s3;
	logic [7:0] group_s2;
	logic [1:0] sector_s2, sector_s3;
	logic [7:0] mp_s3;

	logic [16:0] prod;
	logic [7:0]  group;
	logic [9:0]  rem;
	logic [3:0]  qp, q, q31;
	logic [8:0]  t_sum, mp_sum;
	logic [7:0]  m0_wide;
	logic [4:0]  m0, m1;
	logic [5:0]  m1_sum;

	// Count requests held anywhere between the request port and the back end
	assign busy   = (inflight_q == CNT_W'(DEPTH));
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CNT_W'(accept) - CNT_W'(release_job);
		end
	end

	// Advance the valid bits of the three stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage one: group by reciprocal multiply, sector as the remainder
	always_comb begin
		prod  = {8'b0, cell_id_s1} * 17'd171;
		group = prod[16:9];
		rem   = {1'b0, cell_id_s1} - ({1'b0, group, 1'b0} + {2'b0, group});
	end

	// Stage two: fold the group into the combined shift index
	always_comb begin
		qp     = lte_sss_pkg::quot_small(group_s2, 30);
		t_sum  = {1'b0, group_s2} + {2'b0, lte_sss_pkg::tri_num(qp)};
		q      = lte_sss_pkg::quot_small(t_sum[7:0], 30);
		mp_sum = {1'b0, group_s2} + {2'b0, lte_sss_pkg::tri_num(q)};
	end

	// Stage three: m0 and m1, then order them by subframe
	always_comb begin
		q31     = lte_sss_pkg::quot_small(mp_s3, lte_sss_pkg::SEQ_LEN);
		m0_wide = mp_s3 - 8'({4'b0, q31} * 8'd31);
		m0      = m0_wide[4:0];
		m1_sum  = {1'b0, m0} + {2'b0, q31} + 6'd1;
		if (m1_sum >= 6'(lte_sss_pkg::SEQ_LEN)) begin
			m1_sum = m1_sum - 6'(lte_sss_pkg::SEQ_LEN);
		end
		m1 = m1_sum[4:0];
		push_job.even_shift = sf5_s3 ? m1 : m0;
		push_job.odd_shift  = sf5_s3 ? m0 : m1;
		push_job.z_shift    = sf5_s3 ? m1[2:0] : m0[2:0];
		push_job.sector     = sector_s3;
	end

	assign push = valid_s3;

	// Hold the stage payloads
	always_ff @(posedge clk) begin
		if (accept) begin
			cell_id_s1 <= cell_id;
			sf5_s1     <= subframe_five;
		end
		group_s2  <= group;
		sector_s2 <= rem[1:0];
		sf5_s2    <= sf5_s1;
		mp_s3     <= mp_sum[7:0];
		sector_s3 <= sector_s2;
		sf5_s3    <= sf5_s2;
	end

endmodule

// ----- hw/rtl/lte_sss_queue.sv -----
// Short job queue between the front end and the sequence back end.
module lte_sss_queue #(
	parameter int unsigned DEPTH = lte_sss_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lte_sss_pkg::job_t push_job,
	input  logic              pop,
	output logic              head_valid,
	output lte_sss_pkg::job_t head_job
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	lte_sss_pkg::job_t entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign head_valid = (count_q != '0);
	assign head_job   = entries_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	// Store the incoming job
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue occupancy beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q != CNT_W'(DEPTH))
		else $error("push into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from an empty queue");

endmodule

// ----- hw/rtl/lte_sss_back.sv -----
// Back end: walks the 62 interleaved elements of one job, one per cycle.
module lte_sss_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  lte_sss_pkg::job_t job,
	output logic              pop,
	output logic              strobe,
	output logic [5:0]        element_index,
	output logic              negative,
	output logic              last
);

	lte_sss_pkg::job_t job_q;
	logic              active_q;
	logic [4:0]        n_q;
	logic              odd_q;
	logic              end_elem;
	logic              even_sign, odd_sign;
	logic [4:0]        c1_shift;

	logic              strobe_q;
	logic [5:0]        element_index_q;
	logic              negative_q;
	logic              last_q;

	assign end_elem = active_q && odd_q && (n_q == lte_sss_pkg::LAST_N);
	assign pop      = job_valid && (!active_q || end_elem);

	// Step through the elements, taking the next job straight after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			n_q      <= '0;
			odd_q    <= 1'b0;
		end else if (pop) begin
			active_q <= 1'b1;
			n_q      <= '0;
			odd_q    <= 1'b0;
		end else if (end_elem) begin
			active_q <= 1'b0;
		end else if (active_q) begin
			if (odd_q) begin
				n_q <= n_q + 5'd1;
			end
			odd_q <= ~odd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
		end
	end

	// Look up the shifted sequences for the current element
	always_comb begin
		c1_shift  = {3'b0, job_q.sector} + 5'd3;
		even_sign = lte_sss_pkg::S_SEQ[lte_sss_pkg::add_mod31(n_q, job_q.even_shift)]
			^ lte_sss_pkg::C_SEQ[lte_sss_pkg::add_mod31(n_q, {3'b0, job_q.sector})];
		odd_sign  = lte_sss_pkg::S_SEQ[lte_sss_pkg::add_mod31(n_q, job_q.odd_shift)]
			^ lte_sss_pkg::C_SEQ[lte_sss_pkg::add_mod31(n_q, c1_shift)]
			^ lte_sss_pkg::Z_SEQ[lte_sss_pkg::add_mod31(n_q, {2'b0, job_q.z_shift})];
	end

	// Register the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		element_index_q <= {n_q, odd_q};
		negative_q      <= odd_q ? odd_sign : even_sign;
		last_q          <= end_elem;
	end

	assign strobe        = strobe_q;
	assign element_index = element_index_q;
	assign negative      = negative_q;
	assign last          = last_q;

	a_last_position: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && last_q |-> element_index_q == lte_sss_pkg::LAST_INDEX)
		else $error("last marker away from the final element");

	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !last_q |=> strobe_q && element_index_q == $past(element_index_q) + 6'd1)
		else $error("gap or jump inside a sequence");

endmodule

// ----- verif/sss_element_checker.sv -----
// Checker for the SSS generator: predicts the 62 elements of every request and compares.
`timescale 1ns / 1ps

module sss_element_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [8:0] cell_id,
	input  logic       subframe_five,
	input  logic       strobe,
	input  logic [5:0] element_index,
	input  logic       negative,
	input  logic       last,
	output int         mismatches,
	output int         outstanding
);

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [5:0] index;
		logic       neg;
		logic       fin;
	} sss_element_t;

	// Run the five-stage shift register from x[0..4] = 0,0,0,0,1
	function automatic logic [30:0] shift_register_sequence(input logic [4:0] taps);
		logic [30:0] seq;
		logic [4:0]  window;
		window = 5'b10000;
		for (int i = 0; i < int'(lte_sss_pkg::SEQ_LEN); i++) begin
			seq[i] = window[0];
			window = {^(window & taps), window[4:1]};
		end
		return seq;
	endfunction

	// Cyclic shifts of the two s-sequences for one cell group
	function automatic void group_shifts(input int unsigned grp, output int unsigned m0,
			output int unsigned m1);
		int unsigned q_first, q, m_prime;
		q_first = grp / 30;
		q       = (grp + (q_first * (q_first + 1)) / 2) / 30;
		m_prime = grp + (q * (q + 1)) / 2;
		m0      = m_prime % 31;
		m1      = (m0 + m_prime / 31 + 1) % 31;
	endfunction

	logic [30:0] s_tilde;
	logic [30:0] c_tilde;
	logic [30:0] z_tilde;
	sss_element_t expected_elements[$];

	initial begin
		s_tilde = shift_register_sequence(lte_sss_pkg::TAPS_S);
		c_tilde = shift_register_sequence(lte_sss_pkg::TAPS_C);
		z_tilde = shift_register_sequence(lte_sss_pkg::TAPS_Z);
	end

	// Queue the interleaved elements that one request should produce
	task automatic predict_sequence(input logic [8:0] cid, input logic sf5);
		int unsigned  grp, sector, m0, m1;
		logic         s0, s1, c0, c1, za, zb;
		sss_element_t even_el, odd_el;
		grp    = cid / 3;
		sector = cid % 3;
		group_shifts(grp, m0, m1);
		for (int unsigned n = 0; n < 31; n++) begin
			s0 = s_tilde[(n + m0) % 31];
			s1 = s_tilde[(n + m1) % 31];
			c0 = c_tilde[(n + sector) % 31];
			c1 = c_tilde[(n + sector + 3) % 31];
			za = z_tilde[(n + m0 % 8) % 31];
			zb = z_tilde[(n + m1 % 8) % 31];
			even_el.index = 6'(2 * n);
			odd_el.index  = 6'(2 * n + 1);
			// Subframe 5 swaps the s-sequences and takes its z shift from m1
			if (sf5) begin
				even_el.neg = s1 ^ c0;
				odd_el.neg  = s0 ^ c1 ^ zb;
			end else begin
				even_el.neg = s0 ^ c0;
				odd_el.neg  = s1 ^ c1 ^ za;
			end
			even_el.fin = 1'b0;
			odd_el.fin  = (odd_el.index == lte_sss_pkg::LAST_INDEX);
			expected_elements.push_back(even_el);
			expected_elements.push_back(odd_el);
		end
	endtask

	// Check each strobed element against the oldest prediction, then take new requests
	always @(posedge clk or negedge arst_n) begin
		sss_element_t want;
		if (!arst_n) begin
			expected_elements.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (strobe) begin
				if (expected_elements.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: unexpected element: index %0d negative %0b last %0b",
							$realtime, element_index, negative, last);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_elements.pop_front();
					if (want.index !== element_index || want.neg !== negative ||
							want.fin !== last) begin
						if (mismatches < REPORT_LIMIT)
							$display("%0t: element mismatch: expected index %0d negative %0b last %0b, got index %0d negative %0b last %0b",
								$realtime, want.index, want.neg, want.fin,
								element_index, negative, last);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (start && !busy)
				predict_sequence(cell_id, subframe_five);
			outstanding <= expected_elements.size();
		end
	end

endmodule

// ----- verif/tb_lte_sss_sequence_generator_unit.sv -----
// Top of the SSS generator testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_lte_sss_sequence_generator_unit;

	localparam int RANDOM_REQUESTS = 288;
	localparam int STALL_LIMIT     = 1000;
	localparam int DRAIN_CYCLES    = 10;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       start         = 1'b0;
	logic [8:0] cell_id       = '0;
	logic       subframe_five = 1'b0;
	logic       busy;
	logic       strobe;
	logic [5:0] element_index;
	logic       negative;
	logic       last;
	int         mismatches;
	int         outstanding;

	lte_sss_sequence_generator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cell_id       (cell_id),
		.subframe_five (subframe_five),
		.strobe        (strobe),
		.element_index (element_index),
		.negative      (negative),
		.last          (last)
	);

	sss_element_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cell_id       (cell_id),
		.subframe_five (subframe_five),
		.strobe        (strobe),
		.element_index (element_index),
		.negative      (negative),
		.last          (last),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Present one request and hold it until the block takes it
	task automatic send_request(input logic [8:0] cid, input logic sf5);
		start         <= 1'b1;
		cell_id       <= cid;
		subframe_five <= sf5;
		do @(posedge clk); while (busy);
	endtask

	// Drop start and idle for the given number of cycles
	task automatic pause_requests(input int unsigned cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Abandon the run if nothing moves on either channel for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || strobe)
				quiet = 0;
			else
				quiet++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		logic [8:0]  directed_ids[] = '{9'd0, 9'd0, 9'd503, 9'd503, 9'd504, 9'd511,
			9'd511, 9'd1, 9'd2, 9'd89, 9'd90, 9'd92, 9'd179, 9'd180, 9'd270, 9'd359,
			9'd360, 9'd449, 9'd450, 9'd507, 9'd255, 9'd256};
		logic        directed_sf[] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
			1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
			1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
		int          remaining;
		int unsigned burst;
		logic [8:0]  cid;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, identities beyond range, group boundaries
		foreach (directed_ids[i]) begin
			send_request(directed_ids[i], directed_sf[i]);
			if (i == 5)
				pause_requests(300);
		end
		pause_requests(300);

		// Random bursts with gaps of varying length, including none
		remaining = RANDOM_REQUESTS;
		while (remaining > 0) begin
			burst = $urandom_range(1, 12);
			for (int unsigned b = 0; b < burst && remaining > 0; b++) begin
				case ($urandom_range(0, 9))
					0: cid = 9'($urandom_range(504, 511));
					1: cid = 9'(90 * $urandom_range(0, 5) + $urandom_range(0, 5));
					default: cid = 9'($urandom_range(0, 511));
				endcase
				send_request(cid, 1'($urandom_range(0, 1)));
				remaining--;
			end
			case ($urandom_range(0, 3))
				0: pause_requests(0);
				1: pause_requests($urandom_range(1, 5));
				2: pause_requests($urandom_range(6, 70));
				default: pause_requests($urandom_range(70, 200));
			endcase
		end

		// Drain every predicted element, then watch for stray strobes
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
